@@ hw/rtl/dprm_pkg.sv @@
package dprm_pkg;

    localparam int unsigned NumRegs = 9;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_tick;
    typedef logic [3:0]  t_reg_idx;

    // Access kinds; the unused codes behave as an idle tick
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;

    // Register indexes
    localparam t_reg_idx IX_CTRL        = 4'd0;
    localparam t_reg_idx IX_STATUS      = 4'd1;
    localparam t_reg_idx IX_IRQ         = 4'd2;
    localparam t_reg_idx IX_XFER_LEN    = 4'd5;
    localparam t_reg_idx IX_LINK_STATUS = 4'd6;
    localparam t_reg_idx IX_LINK_CTRL   = 4'd7;
    localparam t_reg_idx IX_PCIE_FIRST  = 4'd6;

    // Address windows: DMA block of six words, PCIe block of three words
    localparam logic [26:0] DMA_WIN_HI  = 27'(32'h4000_0000 >> 5);
    localparam logic [27:0] PCIE_WIN_HI = 28'(32'h5000_0000 >> 4);
    localparam logic [2:0]  DMA_WORDS   = 3'd6;
    localparam logic [1:0]  PCIE_WORDS  = 2'd3;

    localparam t_word RO_MASK [NumRegs] = '{
        32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
        32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
    localparam t_word CLR_MASK [NumRegs] = '{
        32'h0, 32'h0, 32'h7, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h7};
    localparam t_word RESET_VAL [NumRegs] = '{
        32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0};

    localparam t_word STATUS_BUSY     = 32'h2;
    localparam logic [7:0] STATUS_DONE_LO = 8'h05;
    localparam t_word LINK_UP_BASE    = 32'h1 | (32'd16 << 4) | (32'h10 << 10);
    localparam t_word DMA_LATENCY_RST = 32'd10;

    typedef struct packed {
        logic       fire;
        logic [1:0] kind;
        t_word      addr;
        t_word      wdata;
    } t_req;

    typedef struct packed {
        t_word read_data;
        logic  decode_error;
    } t_rsp;

endpackage

@@ hw/rtl/dprm_regfile.sv @@
module dprm_regfile
    import dprm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_word i_dma_latency,
    output t_rsp  o_rsp
);

    t_word r_store [NumRegs];
    t_word n_store [NumRegs];
    t_word store_t [NumRegs];
    t_tick r_tick_nx, n_tick_nx;   // value the tick counter takes on its next advance
    t_tick r_finish, n_finish;
    logic  r_active, n_active;

    logic     dma_hit, pcie_hit, mapped, is_rw, is_write, do_tick, done, active_t;
    t_reg_idx idx;
    t_word    cur, w1c, writable;

    always_comb begin
        dma_hit  = (i_req.addr[31:5] == DMA_WIN_HI) && (i_req.addr[4:2] < DMA_WORDS)
                   && (i_req.addr[1:0] == 2'b00);
        pcie_hit = (i_req.addr[31:4] == PCIE_WIN_HI) && (i_req.addr[3:2] < PCIE_WORDS)
                   && (i_req.addr[1:0] == 2'b00);
        mapped   = dma_hit || pcie_hit;
        if (dma_hit) begin
            idx = {1'b0, i_req.addr[4:2]};
        end else if (pcie_hit) begin
            idx = IX_PCIE_FIRST + {2'b00, i_req.addr[3:2]};
        end else begin
            idx = IX_CTRL;
        end
        is_rw    = (i_req.kind == KIND_READ) || (i_req.kind == KIND_WRITE);
        is_write = i_req.kind == KIND_WRITE;
        do_tick  = i_req.fire && (!is_rw || mapped);

        // Complete a running transfer before the access
        store_t  = r_store;
        active_t = r_active;
        done     = r_active && (r_tick_nx >= r_finish);
        if (done) begin
            store_t[IX_STATUS] = {8'h00, r_store[IX_XFER_LEN][17:2], STATUS_DONE_LO};
            store_t[IX_IRQ][0] = 1'b1;
            active_t           = 1'b0;
        end

        n_store   = r_store;
        n_active  = r_active;
        n_finish  = r_finish;
        n_tick_nx = r_tick_nx;
        w1c       = CLR_MASK[idx];
        writable  = ~(RO_MASK[idx] | w1c);
        cur       = store_t[idx] & ~(i_req.wdata & w1c);
        cur       = (cur & ~writable) | (i_req.wdata & writable);

        if (do_tick) begin
            n_store   = store_t;
            n_active  = active_t;
            n_tick_nx = r_tick_nx + 64'd1;
            if (is_write) begin
                n_store[idx] = cur;
                if (idx == IX_CTRL && i_req.wdata[0] && !active_t) begin
                    n_active           = 1'b1;
                    n_finish           = r_tick_nx + {32'h0, i_dma_latency};
                    n_store[IX_STATUS] = STATUS_BUSY;
                end
                if (idx == IX_LINK_CTRL && i_req.wdata[0]) begin
                    n_store[IX_LINK_STATUS] = LINK_UP_BASE
                                              | {28'h0, i_req.wdata[3:1], 1'b0};
                end
            end
        end

        o_rsp.read_data    = (mapped && i_req.kind == KIND_READ) ? store_t[idx] : '0;
        o_rsp.decode_error = is_rw && !mapped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) begin
                r_store[i] <= RESET_VAL[i];
            end
            r_tick_nx <= 64'd1;
            r_finish  <= '0;
            r_active  <= 1'b0;
        end else begin
            r_store   <= n_store;
            r_tick_nx <= n_tick_nx;
            r_finish  <= n_finish;
            r_active  <= n_active;
        end
    end

endmodule

@@ hw/rtl/dma_pcie_register_model_core.sv @@
// Throughput: one access per cycle while i_out_stall is low. An accepted beat
// passes from the input register through one stage of decode and register
// update logic to the result register; these form the whole path.
// Reset: i_rst_n is synchronous and active low; it restores the register map
// defaults, clears the tick counter and DMA state, and sets dma_latency to 10.
module dma_pcie_register_model_core
    import dprm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // access channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_decode_error
);

    // Input stage
    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    t_word       r_in_addr;
    t_word       r_in_wdata;

    // Result stage
    logic        r_out_valid;
    t_word       r_out_read_data;
    logic        r_out_decode_error;

    t_word       r_dma_latency;

    logic        out_free;   // result register empty or being drained this cycle
    logic        fire;       // held beat is processed and moves to the result register
    logic        load_in;    // input register takes a new beat (or goes empty)
    t_req        req;
    t_rsp        rsp;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign load_in    = !r_in_valid || fire;
    assign o_in_stall = !load_in;

    assign req.fire  = fire;
    assign req.kind  = r_in_kind;
    assign req.addr  = r_in_addr;
    assign req.wdata = r_in_wdata;

    // State update happens at the same edge the result is captured, so the
    // next beat in the input register always sees up to date state.
    dprm_regfile u_regfile (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_dma_latency (r_dma_latency),
        .o_rsp         (rsp)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_dma_latency <= DMA_LATENCY_RST;
        end else begin
            if (load_in) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= fire;
            end
            if (i_cfg_wr_en) begin
                r_dma_latency <= i_cfg_wr_data;
            end
        end
    end

    // Payload: hold while stalled, advance otherwise
    always_ff @(posedge i_clk) begin
        if (load_in && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_addr  <= i_address;
            r_in_wdata <= i_write_data;
        end
        if (fire) begin
            r_out_read_data    <= rsp.read_data;
            r_out_decode_error <= rsp.decode_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_read_data;
    assign o_decode_error = r_out_decode_error;

endmodule
